[rtl/core/udpdmx_pkg.sv]
// udpdmx_pkg: request and response payload types, status codes and
// controller/datapath command types for the udp port demultiplexer
// no dependencies
`default_nettype none
package udpdmx_pkg;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] frame_len;
    logic [15:0] ether_type;
    logic [7:0]  ip_proto;
    logic [31:0] src_ip;
    logic [15:0] src_port;
    logic [15:0] port;
    logic [15:0] udp_len;
    logic [15:0] buffer_handle;
    logic [15:0] max_len;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_src_ip;
    logic [15:0] out_src_port;
    logic [15:0] out_handle;
    logic [15:0] copy_len;
  } rsp_t;

  localparam logic [1:0] REQ_FRAME  = 2'd0;
  localparam logic [1:0] REQ_BIND   = 2'd1;
  localparam logic [1:0] REQ_UNBIND = 2'd2;
  localparam logic [1:0] REQ_RECV   = 2'd3;

  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_ARP     = 3'd1;
  localparam logic [2:0] ST_FORMAT  = 3'd2;
  localparam logic [2:0] ST_UNBOUND = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;
  localparam logic [2:0] ST_REFUSED = 3'd5;
  localparam logic [2:0] ST_EMPTY   = 3'd6;

  localparam logic [15:0] ETYPE_ARP     = 16'h0806;
  localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [15:0] MIN_ARP_FRAME = 16'd42;
  localparam logic [15:0] MIN_IP_FRAME  = 16'd34;
  localparam logic [15:0] UDP_HDR       = 16'd8;

  typedef struct packed {
    logic clear;     // write one zeroed port table entry
    logic capture;   // take the request, read the port table
    logic commit;    // decide, update the port table and the ring
    logic load_out;  // fill the output register
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_stat_t;

endpackage
`default_nettype wire

[rtl/core/udpdmx_req_if.sv]
// udpdmx_req_if: request channel, valid/ready with a req_t payload
// depends on udpdmx_pkg
`default_nettype none
interface udpdmx_req_if;
  import udpdmx_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/udpdmx_rsp_if.sv]
// udpdmx_rsp_if: response channel, valid/ready with a rsp_t payload
// depends on udpdmx_pkg
`default_nettype none
interface udpdmx_rsp_if;
  import udpdmx_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/udpdmx_dp.sv]
// udpdmx_dp: request registers, port table memory, ring entry memory,
// classification and output register
// depends on udpdmx_pkg
`default_nettype none
module udpdmx_dp #(
  parameter int NUM_PORTS   = 256,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  udpdmx_pkg::dp_cmd_t cmd,
  output udpdmx_pkg::dp_stat_t stat,
  input  udpdmx_pkg::req_t    req_data,
  output udpdmx_pkg::rsp_t    rsp_data
);
  import udpdmx_pkg::*;

  localparam int PORTW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int PTRW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDRW = PORTW + PTRW;

  typedef struct packed {
    logic            bound;
    logic [PTRW-1:0] head;
    logic [PTRW-1:0] tail;
    logic [CNTW-1:0] count;
  } pent_t;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [15:0] src_port;
    logic [15:0] plen;
    logic [15:0] handle;
  } qent_t;

  pent_t port_mem [NUM_PORTS];
  qent_t ring_mem [2**ADDRW];

  req_t             rq;
  pent_t            pe;
  qent_t            qe;
  logic [PORTW-1:0] clr_idx;
  logic             arp_seen;
  logic [2:0]       st;
  logic             deq;
  rsp_t             out_reg;

  logic [PORTW-1:0] pidx;
  logic             in_range;
  logic             bound;
  logic [2:0]       st_next;
  logic             deq_next;
  logic             enq;
  logic             pt_wr;
  logic             arp_set;
  pent_t            pe_next;
  logic [PTRW-1:0]  head_inc;
  logic [PTRW-1:0]  tail_inc;
  qent_t            qe_wr;

  assign pidx     = rq.port[PORTW-1:0];
  assign in_range = {1'b0, rq.port} < 17'(NUM_PORTS);
  assign bound    = in_range && pe.bound;
  assign head_inc = (pe.head == PTRW'(QUEUE_DEPTH - 1)) ? '0 : pe.head + 1'b1;
  assign tail_inc = (pe.tail == PTRW'(QUEUE_DEPTH - 1)) ? '0 : pe.tail + 1'b1;
  assign stat.clear_last = (clr_idx == PORTW'(NUM_PORTS - 1));

  always_comb begin
    st_next  = ST_DONE;
    deq_next = 1'b0;
    enq      = 1'b0;
    pt_wr    = 1'b0;
    arp_set  = 1'b0;
    pe_next  = pe;
    case (rq.req_type)
      REQ_FRAME: begin
        if (rq.frame_len >= MIN_ARP_FRAME && rq.ether_type == ETYPE_ARP) begin
          if (arp_seen) begin
            st_next = ST_FORMAT;
          end else begin
            st_next = ST_ARP;
            arp_set = 1'b1;
          end
        end else if (!(rq.frame_len >= MIN_IP_FRAME && rq.ether_type == ETYPE_IPV4)) begin
          st_next = ST_FORMAT;
        end else if (rq.ip_proto != PROTO_UDP || rq.udp_len < UDP_HDR) begin
          st_next = ST_FORMAT;
        end else if (!bound) begin
          st_next = ST_UNBOUND;
        end else if (pe.count >= CNTW'(QUEUE_DEPTH)) begin
          st_next = ST_FULL;
        end else begin
          enq           = 1'b1;
          pt_wr         = 1'b1;
          pe_next.tail  = tail_inc;
          pe_next.count = pe.count + 1'b1;
        end
      end
      REQ_BIND: begin
        if (!in_range || pe.bound) begin
          st_next = ST_REFUSED;
        end else begin
          pt_wr         = 1'b1;
          pe_next.bound = 1'b1;
        end
      end
      REQ_UNBIND: begin
        if (!bound) begin
          st_next = ST_REFUSED;
        end else begin
          pt_wr         = 1'b1;
          pe_next.bound = 1'b0;
        end
      end
      REQ_RECV: begin
        if (!bound) begin
          st_next = ST_UNBOUND;
        end else if (pe.count == '0) begin
          st_next = ST_EMPTY;
        end else begin
          deq_next      = 1'b1;
          pt_wr         = 1'b1;
          pe_next.head  = head_inc;
          pe_next.count = pe.count - 1'b1;
        end
      end
      default: st_next = ST_FORMAT;
    endcase
  end

  always_comb begin
    qe_wr.src_ip   = rq.src_ip;
    qe_wr.src_port = rq.src_port;
    qe_wr.plen     = rq.udp_len - UDP_HDR;
    qe_wr.handle   = rq.buffer_handle;
  end

  // port table: one write port shared by the clearing sweep and updates
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      port_mem[clr_idx] <= '0;
    end else if (cmd.commit && pt_wr) begin
      port_mem[pidx] <= pe_next;
    end
    if (cmd.capture) begin
      pe <= port_mem[req_data.port[PORTW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && enq) begin
      ring_mem[{pidx, pe.tail}] <= qe_wr;
    end
    if (cmd.commit) begin
      qe <= ring_mem[{pidx, pe.head}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx  <= '0;
      arp_seen <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_idx <= stat.clear_last ? '0 : clr_idx + 1'b1;
      end
      if (cmd.commit && arp_set) begin
        arp_seen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rq <= req_data;
    end
    if (cmd.commit) begin
      st  <= st_next;
      deq <= deq_next;
    end
    if (cmd.load_out) begin
      out_reg.status <= st;
      if (deq) begin
        out_reg.out_src_ip   <= qe.src_ip;
        out_reg.out_src_port <= qe.src_port;
        out_reg.out_handle   <= qe.handle;
        out_reg.copy_len     <= (qe.plen < rq.max_len) ? qe.plen : rq.max_len;
      end else begin
        out_reg.out_src_ip   <= '0;
        out_reg.out_src_port <= '0;
        out_reg.out_handle   <= '0;
        out_reg.copy_len     <= '0;
      end
    end
  end

  assign rsp_data = out_reg;

endmodule
`default_nettype wire

[rtl/core/udpdmx_ctrl.sv]
// udpdmx_ctrl: sequencer for the clearing sweep, request lookup, commit
// and response handshake
// depends on udpdmx_pkg
`default_nettype none
module udpdmx_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  req_valid,
  output logic                 req_ready,
  output logic                 rsp_valid,
  input  wire                  rsp_ready,
  output udpdmx_pkg::dp_cmd_t  cmd,
  input  udpdmx_pkg::dp_stat_t stat
);
  import udpdmx_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign req_ready = (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.commit = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // wait here while the previous response is still held
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/udp_port_demux_queues.sv]
// udp_port_demux_queues: udp port demultiplexer with a receive ring per port
// per request: capture with the port table read, commit with the ring read, then
// load the output register once the previous response is taken; no new request is
// taken before that load. reset: synchronous; afterwards a sweep clears all NUM_PORTS
// port table entries, and no request is taken until it ends; ring entries are not cleared
// depends on udpdmx_pkg, udpdmx_req_if, udpdmx_rsp_if, udpdmx_ctrl, udpdmx_dp
`default_nettype none
module udp_port_demux_queues #(
  parameter int NUM_PORTS   = 256,
  parameter int QUEUE_DEPTH = 16
) (
  input wire           clk,
  input wire           rst,
  udpdmx_req_if.sink   req,
  udpdmx_rsp_if.source rsp
);
  import udpdmx_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  udpdmx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  udpdmx_dp #(
    .NUM_PORTS   (NUM_PORTS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .req_data (req.data),
    .rsp_data (rsp.data)
  );

endmodule
`default_nettype wire
